// File: rtl/core/sms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// shared types and constants of the sliding median smoother
// ----------------------------------------------------------------------------
package sms_pkg;

	localparam int WINDOW   = 5;
	localparam int HALF_W   = WINDOW / 2;
	localparam int SAMPLE_W = 16;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int D_W      = (HALF_W > 1) ? $clog2(HALF_W + 1) : 1;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t sample;
		logic    last_sample;
	} sms_in_t;

	typedef struct packed {
		sample_t smoothed;
		logic    last_out;
	} sms_out_t;

	// work handed from front to back: snapshot of the window, newest first
	typedef struct packed {
		sample_t [WINDOW-1:0] win;
		logic    [CNT_W-1:0]  held;
		logic                 last;
	} sms_job_t;

endpackage

// File: rtl/core/sms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_front
// keeps the sample window, decides which transactions make results
// ----------------------------------------------------------------------------
module sms_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              smp_valid,
	output logic              smp_ready,
	input  sms_pkg::sms_in_t  smp_data,
	output logic              job_valid,
	input  logic              job_ready,
	output sms_pkg::sms_job_t job
);
	import sms_pkg::*;

	sample_t [WINDOW-1:0] win_q;
	sample_t [WINDOW-1:0] win_next;
	logic    [CNT_W-1:0]  seen_q;
	logic    [CNT_W-1:0]  held_next;
	logic                 take;

	assign smp_ready = job_ready;
	assign take      = smp_valid && smp_ready;

	always_comb begin
		win_next[0] = smp_data.sample;
		for (int k = 1; k < WINDOW; k++) begin
			win_next[k] = win_q[k-1];
		end
		held_next = (seen_q < CNT_W'(WINDOW)) ? seen_q + CNT_W'(1) : seen_q;
	end

	// a result exists once the centre has a full right side, or on a final sample
	assign job_valid = smp_valid &&
		(smp_data.last_sample || (held_next >= CNT_W'(HALF_W + 1)));
	assign job.win  = win_next;
	assign job.held = held_next;
	assign job.last = smp_data.last_sample;

	always_ff @(posedge clk) begin
		if (take) begin
			win_q <= win_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (take) begin
			seen_q <= smp_data.last_sample ? '0 : held_next;
		end
	end

`ifndef SYNTHESIS
	a_seen_range: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(WINDOW))
		else $error("seen count beyond window");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && smp_data.last_sample |=> seen_q == '0)
		else $error("sequence end did not clear count");
	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> job.held != '0)
		else $error("job with empty window");
`endif

endmodule

// File: rtl/core/sms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module sms_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  sms_pkg::sms_job_t push_job,
	output logic              pop_valid,
	input  logic              pop_ready,
	output sms_pkg::sms_job_t pop_job
);
	import sms_pkg::*;

	sms_job_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCNT_W'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
	a_empty_next: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 && !push |=> count_q == '0)
		else $error("queue count moved without push");
`endif

endmodule

// File: rtl/core/sms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_back
// rank-based median over a cut window, one result per cycle unless results stall
// ----------------------------------------------------------------------------
module sms_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  sms_pkg::sms_job_t job,
	output logic              res_valid,
	input  logic              res_ready,
	output sms_pkg::sms_out_t res_data
);
	import sms_pkg::*;

	logic               active_q;
	logic [D_W-1:0]     idx_q;
	logic               res_valid_q;
	sms_out_t           res_q;
	logic [CNT_W-1:0]   held_m1;
	logic [D_W-1:0]     dmax;
	logic [D_W-1:0]     cur_d;
	logic [CNT_W-1:0]   span;
	logic [CNT_W-1:0]   cnt;
	logic [CNT_W-1:0]   rank [WINDOW];
	logic [CNT_W-1:0]   lo_rank;
	logic [CNT_W-1:0]   hi_rank;
	sample_t            lo_val;
	sample_t            hi_val;
	logic [SAMPLE_W:0]  mid_sum;
	logic               advance;
	logic               done;

	// positions still owed on a sequence end: the centre and up to HALF_W after it
	assign held_m1 = job.held - CNT_W'(1);
	assign dmax    = (held_m1 > CNT_W'(HALF_W)) ? D_W'(HALF_W) : D_W'(held_m1);
	assign cur_d   = active_q ? idx_q : dmax;
	assign span    = CNT_W'(cur_d) + CNT_W'(HALF_W + 1);
	assign cnt     = (job.last && span < job.held) ? span : job.held;

	// rank each live entry, ties broken by position, then pick the middle pair
	always_comb begin
		lo_rank = (cnt - CNT_W'(1)) >> 1;
		hi_rank = cnt >> 1;
		lo_val  = '0;
		hi_val  = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j != i && CNT_W'(j) < cnt &&
					((job.win[j] < job.win[i]) || (job.win[j] == job.win[i] && j < i))) begin
					rank[i] = rank[i] + CNT_W'(1);
				end
			end
			if (CNT_W'(i) < cnt && rank[i] == lo_rank) begin
				lo_val = lo_val | job.win[i];
			end
			if (CNT_W'(i) < cnt && rank[i] == hi_rank) begin
				hi_val = hi_val | job.win[i];
			end
		end
		mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
	end

	assign advance   = job_valid && (!res_valid_q || res_ready);
	assign done      = !job.last || (cur_d == '0);
	assign job_ready = advance && done;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.smoothed <= mid_sum[SAMPLE_W:1];
			res_q.last_out <= job.last && (cur_d == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (advance) begin
				active_q <= !done;
				idx_q    <= cur_d - D_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_active_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> job_valid && job.last)
		else $error("flush in progress without a final job");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> idx_q < D_W'(HALF_W))
		else $error("flush index out of range");
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> cnt != '0 && cnt <= CNT_W'(WINDOW))
		else $error("bad window count");
`endif

endmodule

// File: rtl/core/sliding_median_smoother_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_smoother_core
// sliding-window median over a sample sequence, window cut at the edges
// ----------------------------------------------------------------------------
//
//  channel | valid     | ready     | payload             | role
//  --------+-----------+-----------+---------------------+----------------------
//  smp     | smp_valid | smp_ready | smp_data (sms_in_t) | one sample per transaction
//  res     | res_valid | res_ready | res_data (sms_out_t)| one smoothed value
//
//  - a sample can be taken every cycle while the queue has room; a non-final
//    sample makes at most one result; the back end gives one per cycle unless stalled
//  - the final sample makes min(held, WINDOW/2 + 1) results, one per cycle out of
//    the back end unless results stall; it holds the back end until the last is out
//  - a sample's job is registered in the queue, its result in the output register
//  - reset clears counters, queue pointers and valids; no clearing pass is needed
//  - the two-entry queue lets the sample side go on while results stall, until full
//
module sliding_median_smoother_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              smp_valid,
	output logic              smp_ready,
	input  sms_pkg::sms_in_t  smp_data,
	output logic              res_valid,
	input  logic              res_ready,
	output sms_pkg::sms_out_t res_data
);
	import sms_pkg::*;

	// front to queue
	logic     fq_valid;
	logic     fq_ready;
	sms_job_t fq_job;

	// queue to back
	logic     qb_valid;
	logic     qb_ready;
	sms_job_t qb_job;

	// window register and count; hands over a window snapshot per result-making sample
	sms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp_data  (smp_data),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	// decouples sample intake from the multi-result flush at sequence end
	sms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_job   (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_job    (qb_job)
	);

	// median select and output register
	sms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

`ifndef SYNTHESIS
	a_final_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && smp_data.last_sample |-> fq_valid && fq_ready)
		else $error("final sample taken without queuing its flush");
	a_no_result_from_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!qb_valid && !res_valid |=> !res_valid)
		else $error("result without pending work");
	// a queued job waits only for a result stall or for its own flush
	a_back_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		qb_valid && !qb_ready |-> qb_job.last || (res_valid && !res_ready))
		else $error("back end held a job without cause");
`endif

endmodule

// File: tb/sliding_median_smoother_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_smoother_core_tb
// self-checking bench for the sliding-window median smoother
// ----------------------------------------------------------------------------
// Sample sequences are streamed into the block over the sample channel. A
// predictor inside the bench keeps its own window of recent samples and works
// out the medians that each sample releases, including the flush on the final
// sample. Every result transaction is checked field by field against the
// oldest pending median. The tests cover directed edge sequences, random
// sequences under random idling on both sides, a drain pause, and a final
// back-to-back stretch with no idling.
// ----------------------------------------------------------------------------
module sliding_median_smoother_core_tb;

	import sms_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     smp_valid;
	logic     smp_ready;
	sms_in_t  smp_data;
	logic     res_valid;
	logic     res_ready;
	sms_out_t res_data;

	// idling switches for the sample side and the result side
	bit       src_idle_en;
	bit       sink_stall_en;

	// predictor state: recent samples, newest at index 0, and how many are held
	sample_t  window_hist [WINDOW];
	int       held_cnt;

	// medians predicted but not yet seen on the result channel
	sms_out_t pending_medians [$];

	int       samples_sent;
	int       seq_cnt;
	int       results_checked;
	int       err_cnt;

	sliding_median_smoother_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.smp_data  (smp_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout: %0d medians still pending", pending_medians.size());
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// median of the newest cnt samples, floor of the mean of the middle pair
	// when cnt is even
	function automatic sample_t window_median(int cnt);
		sample_t           srt [WINDOW];
		logic [SAMPLE_W:0] pair_sum;
		int                b;
		for (int a = 0; a < cnt; a++) begin
			b = a;
			while (b > 0 && srt[b-1] > window_hist[a]) begin
				srt[b] = srt[b-1];
				b--;
			end
			srt[b] = window_hist[a];
		end
		if (cnt % 2 == 1)
			return srt[cnt/2];
		pair_sum = {1'b0, srt[cnt/2-1]} + {1'b0, srt[cnt/2]};
		return pair_sum[SAMPLE_W:1];
	endfunction

	// shift one accepted sample in and queue the medians it releases
	function automatic void predict_medians(sample_t s, logic last);
		sms_out_t r;
		int       dmax;
		int       cnt;
		for (int k = WINDOW - 1; k > 0; k--)
			window_hist[k] = window_hist[k-1];
		window_hist[0] = s;
		if (held_cnt < WINDOW)
			held_cnt++;

		if (!last) begin
			// centre position is reached once half a window past it is held
			if (held_cnt >= HALF_W + 1) begin
				r.smoothed = window_median(held_cnt);
				r.last_out = 1'b0;
				pending_medians.push_back(r);
			end
			return;
		end

		// final sample: flush every position still owed, oldest first, with
		// the window cut at the tail (and at the head for short sequences)
		dmax = (held_cnt - 1 > HALF_W) ? HALF_W : held_cnt - 1;
		for (int d = dmax; d >= 0; d--) begin
			cnt = d + HALF_W + 1;
			if (cnt > held_cnt)
				cnt = held_cnt;
			r.smoothed = window_median(cnt);
			r.last_out = (d == 0);
			pending_medians.push_back(r);
		end

		// block restarts its held count for the next sequence
		foreach (window_hist[k])
			window_hist[k] = '0;
		held_cnt = 0;
	endfunction

	// ------------------------------------------------------------------------
	// result side: random stall bursts on res_ready
	// ------------------------------------------------------------------------
	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_stall_en && $urandom_range(0, 4) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	task automatic report_mismatch(string what, sms_out_t exp_r, sms_out_t act_r);
		err_cnt++;
		if (err_cnt <= 10)
			$display("[%0t] %s: expected smoothed=%h last_out=%b, got smoothed=%h last_out=%b",
				$realtime, what, exp_r.smoothed, exp_r.last_out,
				act_r.smoothed, act_r.last_out);
	endtask

	// result checker: one pending median per result transaction
	always @(posedge clk) begin
		sms_out_t exp_r;
		if (arst_n && res_valid && res_ready) begin
			if (pending_medians.size() == 0) begin
				exp_r = '0;
				report_mismatch("result with nothing pending", exp_r, res_data);
			end else begin
				exp_r = pending_medians.pop_front();
				results_checked++;
				if (res_data.smoothed !== exp_r.smoothed)
					report_mismatch("smoothed mismatch", exp_r, res_data);
				else if (res_data.last_out !== exp_r.last_out)
					report_mismatch("last_out mismatch", exp_r, res_data);
			end
		end
	end

	// ------------------------------------------------------------------------
	// sample side
	// ------------------------------------------------------------------------

	// one sample transaction; valid is only dropped for an idle burst
	task automatic send_sample(sample_t s, logic last);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			smp_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		smp_valid <= 1'b1;
		smp_data  <= '{sample: s, last_sample: last};
		do
			@(posedge clk);
		while (!smp_ready);
		predict_medians(s, last);
		samples_sent++;
		if (last)
			seq_cnt++;
	endtask

	// whole sequence from a list, final flag on the tail entry
	task automatic send_list(sample_t vals [$]);
		foreach (vals[i])
			send_sample(vals[i], i == vals.size() - 1);
	endtask

	// skewed toward the extremes and near-ties, rest fully random
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return sample_t'($urandom_range(0, 3));
			3:       return sample_t'(16'hFFFF - $urandom_range(0, 3));
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_random_sequence(int len);
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(), i == len - 1);
	endtask

	// sender holds off until the result side has caught up
	task automatic wait_drained();
		smp_valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// short and cut windows, extremes, odd sum in an even window, saturation
	task automatic test_directed_edges();
		// single-sample sequence: one median equal to the sample
		send_list('{16'hFFFF});
		// two samples: even cut window everywhere, floor of odd sum
		send_list('{16'h0000, 16'hFFFF});
		// exactly half a window plus one
		send_list('{16'h0005, 16'h0002, 16'h0009});
		// four samples, mixed cut windows at both ends
		send_list('{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE});
		// long sequence, held count saturates, both extremes and their neighbours
		send_list('{16'hFFFF, 16'hFFFE, 16'h0000, 16'h0001,
			16'hAAAA, 16'h5555, 16'h8000, 16'h0003});
	endtask

	// random sequences, mostly short, some long, with idling on both sides
	task automatic test_random_sequences();
		int len;
		int sent_before;
		sent_before = samples_sent;
		while (samples_sent - sent_before < 100) begin
			case ($urandom_range(0, 9))
				0:       len = $urandom_range(1, 2);
				1, 2:    len = $urandom_range(9, 24);
				default: len = $urandom_range(3, 8);
			endcase
			send_random_sequence(len);
		end
	endtask

	// sender pauses for a full drain, mid-sequence and between sequences
	task automatic test_drain_pause();
		for (int i = 0; i < 4; i++)
			send_sample(pick_sample(), 1'b0);
		wait_drained();
		for (int i = 0; i < 3; i++)
			send_sample(pick_sample(), i == 2);
		wait_drained();
		send_random_sequence(2);
	endtask

	// no idling at all: back-to-back samples and an always-ready sink
	task automatic test_back_to_back();
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b0;
		send_random_sequence(1);
		send_random_sequence(12);
		send_random_sequence(2);
		send_random_sequence(7);
		send_random_sequence(3);
		send_random_sequence(6);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		smp_valid       = 1'b0;
		smp_data        = '0;
		src_idle_en     = 1'b1;
		sink_stall_en   = 1'b1;
		held_cnt        = 0;
		samples_sent    = 0;
		seq_cnt         = 0;
		results_checked = 0;
		err_cnt         = 0;
		foreach (window_hist[k])
			window_hist[k] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_random_sequences();
		test_drain_pause();
		test_back_to_back();

		// let the last flush come out, then a few quiet cycles
		wait_drained();
		repeat (10) @(posedge clk);

		if (pending_medians.size() != 0) begin
			err_cnt++;
			$display("%0d medians never arrived", pending_medians.size());
		end

		$display("covered %0d samples in %0d sequences, %0d medians checked",
			samples_sent, seq_cnt, results_checked);
		$display("cut windows, flush on final sample, drain pause, back-to-back; %0d errors",
			err_cnt);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sliding_median_smoother_core.f
rtl/core/sms_pkg.sv
rtl/core/sms_front.sv
rtl/core/sms_queue.sv
rtl/core/sms_back.sv
rtl/core/sliding_median_smoother_core.sv
tb/sliding_median_smoother_core_tb.sv
